// ===== hw/rtl/wvtc_pkg.sv =====
// Package: shared constants, types and saturation helper for the teleoperation coupler.
`timescale 1ns / 1ps
`default_nettype none
package wvtc_pkg;

    localparam int DELAY_DEPTH = 5;
    localparam int SLOT_W      = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int WORD_W      = 128;
    localparam int PROD_W      = 68;
    localparam int MX_W        = 35;
    localparam int MY_W        = 33;

    localparam logic [2:0] REG_WAVE_IMPEDANCE   = 3'd0;
    localparam logic [2:0] REG_FILTER_BANDWIDTH = 3'd1;
    localparam logic [2:0] REG_SQRT_TWO_IMP     = 3'd2;
    localparam logic [2:0] REG_INV_SQRT_TWO_IMP = 3'd3;
    localparam logic [2:0] REG_INV_TWO_PLUS_BW  = 3'd4;

    localparam logic [3:0] STEP_GAIN     = 4'd0;
    localparam logic [3:0] STEP_FPREV    = 4'd1;
    localparam logic [3:0] STEP_RAW      = 4'd2;
    localparam logic [3:0] STEP_DIVISOR  = 4'd3;
    localparam logic [3:0] STEP_FILTERED = 4'd4;
    localparam logic [3:0] STEP_CORRECT  = 4'd5;
    localparam logic [3:0] STEP_WAVE_MUL = 4'd6;
    localparam logic [3:0] STEP_FORCE    = 4'd7;
    localparam logic [3:0] STEP_NEW_MUL  = 4'd8;
    localparam logic [3:0] STEP_NEW_WAVE = 4'd9;
    localparam logic [3:0] STEP_LAST     = STEP_NEW_WAVE;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       run;
        logic [3:0] step;
    } lane_ctrl_t;

    typedef struct packed {
        logic [30:0] wave_impedance;
        logic [16:0] filter_bandwidth;
        logic [30:0] sqrt_two_impedance;
        logic [30:0] inv_sqrt_two_impedance;
        logic [16:0] inv_two_plus_bandwidth;
    } cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(33'sh0_7FFF_FFFF);
        lo = -PROD_W'(33'sh0_8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/wvtc_lane.sv =====
// Per-joint datapath: wave filter, drift correction, force and new wave over a shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
module wvtc_lane (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire wvtc_pkg::lane_ctrl_t ctrl,
    input  wire wvtc_pkg::cfg_t       cfg,
    input  wire logic signed [31:0]   wave_in,
    input  wire logic signed [31:0]   partner_pos,
    input  wire logic signed [31:0]   position,
    input  wire logic signed [31:0]   velocity,
    output logic signed [31:0]        force_out,
    output logic signed [31:0]        new_wave
);
    import wvtc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [31:0]       k_reg;
    logic signed [31:0]       e_reg;
    logic signed [31:0]       f_reg;
    logic signed [31:0]       wf_reg;
    logic signed [47:0]       mbv_reg;
    logic signed [31:0]       force_reg;
    logic signed [31:0]       d_reg;
    logic signed [31:0]       nw_reg;
    logic signed [31:0]       prev_raw_reg;
    logic signed [31:0]       prev_filt_reg;

    logic signed [MX_W-1:0]   mx;
    logic signed [MY_W-1:0]   my;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] shifted;
    logic signed [PROD_W-1:0] acc;
    logic signed [18:0]       two_minus_bw;
    logic signed [31:0]       c_raw;
    logic signed [32:0]       c_abs;
    logic signed [32:0]       f_abs;
    logic signed [32:0]       c_fix;
    logic signed [31:0]       wf_next;
    logic signed [31:0]       f_next;
    logic signed [31:0]       force_next;

    assign shifted      = prod_reg >>> 16;
    assign acc          = prod_reg + p1_reg;
    assign two_minus_bw = 19'sd131072 - $signed({2'b00, cfg.filter_bandwidth});
    assign f_next       = sat32(shifted);
    assign c_raw        = sat32(shifted);
    assign force_next   = sat32(shifted - PROD_W'(mbv_reg));

    always_comb begin
        c_abs = (c_raw < 0) ? -33'(c_raw) : 33'(c_raw);
        f_abs = (f_reg < 0) ? -33'(f_reg) : 33'(f_reg);
        if ((e_reg < 0 && f_reg > 0) || (e_reg > 0 && f_reg < 0)) begin
            c_fix = '0;
        end else if (c_abs > f_abs) begin
            c_fix = -33'(f_reg);
        end else begin
            c_fix = 33'(c_raw);
        end
        wf_next = sat32(PROD_W'(f_reg) + PROD_W'(c_fix));
    end

    always_comb begin
        mx = '0;
        my = '0;
        case (ctrl.step)
            STEP_GAIN: begin
                mx = MX_W'($signed({1'b0, cfg.sqrt_two_impedance}));
                my = MY_W'($signed({1'b0, cfg.filter_bandwidth}));
            end
            STEP_FPREV: begin
                mx = MX_W'(two_minus_bw);
                my = MY_W'(prev_filt_reg);
            end
            STEP_RAW: begin
                mx = MX_W'($signed({1'b0, cfg.filter_bandwidth}));
                my = MY_W'(wave_in) + MY_W'(prev_raw_reg);
            end
            STEP_DIVISOR: begin
                mx = MX_W'(acc >>> 16);
                my = MY_W'($signed({1'b0, cfg.inv_two_plus_bandwidth}));
            end
            STEP_FILTERED: begin
                mx = MX_W'(k_reg);
                my = MY_W'(e_reg);
            end
            STEP_CORRECT: begin
                mx = MX_W'($signed({1'b0, cfg.wave_impedance}));
                my = MY_W'(velocity);
            end
            STEP_WAVE_MUL: begin
                mx = MX_W'($signed({1'b0, cfg.sqrt_two_impedance}));
                my = MY_W'(wf_reg);
            end
            STEP_NEW_MUL: begin
                mx = MX_W'(d_reg);
                my = MY_W'($signed({1'b0, cfg.inv_sqrt_two_impedance}));
            end
            default: begin
                mx = '0;
                my = '0;
            end
        endcase
        prod_next = PROD_W'(mx) * PROD_W'(my);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_raw_reg  <= '0;
            prev_filt_reg <= '0;
        end else if (ctrl.run) begin
            case (ctrl.step)
                STEP_DIVISOR:  prev_raw_reg  <= wave_in;
                STEP_FILTERED: prev_filt_reg <= f_next;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.run) begin
            prod_reg <= prod_next;
            case (ctrl.step)
                STEP_FPREV: begin
                    k_reg <= sat32(shifted);
                    e_reg <= sat32(PROD_W'(partner_pos) - PROD_W'(position));
                end
                STEP_RAW:      p1_reg    <= prod_reg;
                STEP_FILTERED: f_reg     <= f_next;
                STEP_CORRECT:  wf_reg    <= wf_next;
                STEP_WAVE_MUL: mbv_reg   <= shifted[47:0];
                STEP_FORCE: begin
                    force_reg <= force_next;
                    d_reg     <= sat32(PROD_W'(mbv_reg) - PROD_W'(force_next));
                end
                STEP_NEW_WAVE: nw_reg    <= sat32(shifted);
                default: begin
                end
            endcase
        end
    end

    assign force_out = force_reg;
    assign new_wave  = nw_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/wave_variable_teleop_coupler.sv =====
// Top level: wave-variable teleoperation coupler for two joints with a delay ring memory.
//
// s_ channel carries one control tick: positions and velocities of joints A and B.
// m_ channel returns the two force commands for that tick, one transfer per input.
// Each tick reads one ring slot (delayed waves and partner positions), runs both
// joints in parallel lanes of ten multiply steps each, writes the slot back with
// the new waves and positions, and advances the slot.
// A tick passes through the memory read, the ten lane steps, the write-back and the
// output load in that order; a new tick is taken only once the block is back in idle.
// The output register holds a finished result while the next tick is computed;
// a stalled receiver holds the block in the output load state until the
// pending result is taken.
// Reset clears the ring valid bits, the filter history, the slot counter and
// returns the registers to their defaults; unwritten ring slots read as zero.
// Registers sit on the APB port at byte address 4*i; write them only while no
// tick is in flight.
`timescale 1ns / 1ps
`default_nettype none
module wave_variable_teleop_coupler (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [127:0] s_tdata,   // position_a, velocity_a, position_b, velocity_b
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // force_a, force_b
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [4:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wvtc_pkg::*;

    state_t                    state_reg;
    state_t                    state_next;
    logic [3:0]                step_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [DELAY_DEPTH-1:0]    valid_reg;
    logic [WORD_W-1:0]         ring_mem [DELAY_DEPTH];
    logic [WORD_W-1:0]         rd_reg;
    logic                      rd_valid_reg;
    logic [127:0]              in_reg;
    logic                      out_valid_reg;
    logic [63:0]               out_data_reg;
    cfg_t                      cfg_reg;

    logic                      accept;
    logic                      mem_we;
    logic                      out_load;
    lane_ctrl_t                ctrl;
    logic [WORD_W-1:0]         rd_word;
    logic [WORD_W-1:0]         wr_word;
    logic                      cfg_we;
    logic signed [31:0]        force_a;
    logic signed [31:0]        force_b;
    logic signed [31:0]        nw_a;
    logic signed [31:0]        nw_b;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wave_impedance         <= 31'd65536;
            cfg_reg.filter_bandwidth       <= 17'd1311;
            cfg_reg.sqrt_two_impedance     <= 31'd92682;
            cfg_reg.inv_sqrt_two_impedance <= 31'd46341;
            cfg_reg.inv_two_plus_bandwidth <= 17'd32444;
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_WAVE_IMPEDANCE:   cfg_reg.wave_impedance         <= pwdata[30:0];
                REG_FILTER_BANDWIDTH: cfg_reg.filter_bandwidth       <= pwdata[16:0];
                REG_SQRT_TWO_IMP:     cfg_reg.sqrt_two_impedance     <= pwdata[30:0];
                REG_INV_SQRT_TWO_IMP: cfg_reg.inv_sqrt_two_impedance <= pwdata[30:0];
                REG_INV_TWO_PLUS_BW:  cfg_reg.inv_two_plus_bandwidth <= pwdata[16:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_WAVE_IMPEDANCE:   prdata = {1'b0, cfg_reg.wave_impedance};
            REG_FILTER_BANDWIDTH: prdata = {15'd0, cfg_reg.filter_bandwidth};
            REG_SQRT_TWO_IMP:     prdata = {1'b0, cfg_reg.sqrt_two_impedance};
            REG_INV_SQRT_TWO_IMP: prdata = {1'b0, cfg_reg.inv_sqrt_two_impedance};
            REG_INV_TWO_PLUS_BW:  prdata = {15'd0, cfg_reg.inv_two_plus_bandwidth};
            default:              prdata = '0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_READ;
            ST_READ:  state_next = ST_CALC;
            ST_CALC:  if (step_reg == STEP_LAST) state_next = ST_WRITE;
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        ctrl.run = 1'b0;
        ctrl.step = step_reg;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_CALC:  ctrl.run = 1'b1;
            ST_WRITE: mem_we = 1'b1;
            ST_DONE:  out_load = !out_valid_reg || m_tready;
            default: begin
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            slot_reg  <= '0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (ctrl.run) begin
                step_reg <= (step_reg == STEP_LAST) ? '0 : step_reg + 4'd1;
            end
            if (mem_we) begin
                valid_reg[slot_reg] <= 1'b1;
                slot_reg <= (slot_reg == SLOT_W'(DELAY_DEPTH - 1)) ? '0
                                                                   : slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_tdata;
        end
        if (state_reg == ST_READ) begin
            rd_reg       <= ring_mem[slot_reg];
            rd_valid_reg <= valid_reg[slot_reg];
        end
        if (mem_we) begin
            ring_mem[slot_reg] <= wr_word;
        end
    end

    assign rd_word = rd_valid_reg ? rd_reg : '0;
    assign wr_word = {in_reg[31:0], in_reg[95:64], nw_a, nw_b};

    wvtc_lane u_lane_a (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .cfg         (cfg_reg),
        .wave_in     ($signed(rd_word[31:0])),
        .partner_pos ($signed(rd_word[95:64])),
        .position    ($signed(in_reg[31:0])),
        .velocity    ($signed(in_reg[63:32])),
        .force_out   (force_a),
        .new_wave    (nw_a)
    );

    wvtc_lane u_lane_b (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .cfg         (cfg_reg),
        .wave_in     ($signed(rd_word[63:32])),
        .partner_pos ($signed(rd_word[127:96])),
        .position    ($signed(in_reg[95:64])),
        .velocity    ($signed(in_reg[127:96])),
        .force_out   (force_b),
        .new_wave    (nw_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {force_b, force_a};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/wvtc_checker.sv =====
// Port-level checker for the teleoperation coupler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module wvtc_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [63:0]  m_tdata
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
        else $error("input taken while a tick is in progress");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_no_fast_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid ##1 !m_tvalid)
        else $error("result appeared too early");

endmodule

bind wave_variable_teleop_coupler wvtc_checker u_wvtc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the wave-variable teleoperation coupler: directed table plus random ticks.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import wvtc_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // position_a, velocity_a, position_b, velocity_b
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;        // force_a, force_b
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    wave_variable_teleop_coupler dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    typedef struct {
        logic [31:0] pa, va, pb, vb;
        bit          fixed;
        logic [31:0] fa, fb;
    } tick_row_t;

    // predictor state
    longint imp, bw, s2b, is2b, i2bw;
    longint wring_a[DELAY_DEPTH], wring_b[DELAY_DEPTH];
    longint pring_a[DELAY_DEPTH], pring_b[DELAY_DEPTH];
    longint raw_hist[2], filt_hist[2];
    int     slot;

    logic [63:0] force_queue[$];
    int errors = 0;
    int sent = 0;
    int got = 0;
    int idle_cycles = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fmul(longint x, longint y);
        return (x * y) >>> 16;
    endfunction

    function automatic longint filter_lane(longint w, int j);
        longint acc, f;
        acc = (64'sd131072 - bw) * filt_hist[j] + bw * (w + raw_hist[j]);
        f = clamp32(fmul(acc >>> 16, i2bw));
        raw_hist[j] = w;
        filt_hist[j] = f;
        return f;
    endfunction

    function automatic longint drift_fix(longint f, longint pp, longint p);
        longint e, k, c, ac, af;
        e = clamp32(pp - p);
        k = clamp32(fmul(s2b, bw));
        c = clamp32(fmul(k, e));
        ac = c < 0 ? -c : c;
        af = f < 0 ? -f : f;
        if ((e < 0 && f > 0) || (e > 0 && f < 0)) c = 0;
        else if (ac > af) c = -f;
        return clamp32(f + c);
    endfunction

    function automatic logic [63:0] predict_forces(logic [127:0] d);
        longint pa, va, pb, vb, fa, fb, ka, kb;
        pa = longint'($signed(d[31:0]));
        va = longint'($signed(d[63:32]));
        pb = longint'($signed(d[95:64]));
        vb = longint'($signed(d[127:96]));
        fa = filter_lane(wring_a[slot], 0);
        fb = filter_lane(wring_b[slot], 1);
        fa = drift_fix(fa, pring_a[slot], pa);
        ka = clamp32(fmul(s2b, fa) - fmul(imp, va));
        fb = drift_fix(fb, pring_b[slot], pb);
        kb = clamp32(fmul(s2b, fb) - fmul(imp, vb));
        wring_b[slot] = clamp32(fmul(clamp32(fmul(imp, va) - ka), is2b));
        pring_b[slot] = pa;
        wring_a[slot] = clamp32(fmul(clamp32(fmul(imp, vb) - kb), is2b));
        pring_a[slot] = pb;
        slot = (slot + 1) % DELAY_DEPTH;
        return {kb[31:0], ka[31:0]};
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_WAVE_IMPEDANCE:   imp  = longint'(val[30:0]);
            REG_FILTER_BANDWIDTH: bw   = longint'(val[16:0]);
            REG_SQRT_TWO_IMP:     s2b  = longint'(val[30:0]);
            REG_INV_SQRT_TWO_IMP: is2b = longint'(val[30:0]);
            REG_INV_TWO_PLUS_BW:  i2bw = longint'(val[16:0]);
            default: ;
        endcase
    endtask

    // advance the predictor always; queue the typed-in value for fixed rows
    task automatic send_tick(logic [127:0] d, bit fixed = 1'b0, logic [63:0] fixed_val = '0);
        int gap;
        logic [63:0] exp_f;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        exp_f = predict_forces(d);
        if (fixed) exp_f = fixed_val;
        force_queue.push_back(exp_f);
        sent++;
    endtask

    task automatic drain_wait();
        s_tvalid <= 1'b0;
        while (force_queue.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 262144))
                                           : -32'($urandom_range(0, 262144));
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stall per transfer
    int stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got++;
                if (force_queue.size() == 0) begin
                    $display("%0t: unexpected transfer %h", $time, m_tdata);
                    errors++;
                end else begin
                    logic [63:0] exp_f;
                    exp_f = force_queue.pop_front();
                    if (exp_f[31:0] !== m_tdata[31:0]) begin
                        $display("%0t: force_a expected %h actual %h", $time,
                                 exp_f[31:0], m_tdata[31:0]);
                        errors++;
                    end
                    if (exp_f[63:32] !== m_tdata[63:32]) begin
                        $display("%0t: force_b expected %h actual %h", $time,
                                 exp_f[63:32], m_tdata[63:32]);
                        errors++;
                    end
                end
                stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("Verification failed");
            $finish;
        end
    end

    tick_row_t rows[$];
    logic [31:0] cfg_vals[5];

    initial begin
        imp = 65536; bw = 1311; s2b = 92682; is2b = 46341; i2bw = 32444;
        for (int i = 0; i < DELAY_DEPTH; i++) begin
            wring_a[i] = 0; wring_b[i] = 0; pring_a[i] = 0; pring_b[i] = 0;
        end
        raw_hist = '{0, 0}; filt_hist = '{0, 0}; slot = 0;

        // after reset with zero velocity the force is zero
        rows.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0});
        // unit velocity, b = 1.0, empty rings: force = -v
        rows.push_back('{32'h0, 32'h0001_0000, 32'h0, 32'hFFFF_0000, 1,
                         32'hFFFF_0000, 32'h0001_0000});
        rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0, 0});
        rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0});
        rows.push_back('{32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0, 0, 0, 0});
        for (int i = 0; i < 12; i++) begin
            // positions chosen to make error and wave agree, oppose, or exceed
            rows.push_back('{32'(i * 40000) - 32'd200000, 32'(i * 3000),
                             32'd200000 - 32'(i * 40000), -32'(i * 5000), 0, 0, 0});
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            logic [127:0] d;
            d = {rows[i].vb, rows[i].pb, rows[i].va, rows[i].pa};
            send_tick(d, rows[i].fixed, {rows[i].fb, rows[i].fa});
        end
        drain_wait();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: cfg_vals = '{32'h0000_8000, 32'd6554, 32'd65536, 32'd65536, 32'd31118};
                1: cfg_vals = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
                2: cfg_vals = '{32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h0001_0000};
                3: cfg_vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF};
                7: cfg_vals = '{32'd65536, 32'd1311, 32'd92682, 32'd46341, 32'd32444};
                default: cfg_vals = '{$urandom_range(0, 32'h0004_0000), $urandom_range(0, 65536),
                                      $urandom_range(0, 32'h0004_0000),
                                      $urandom_range(0, 32'h0004_0000),
                                      $urandom_range(0, 65536)};
            endcase
            for (int k = 0; k < 5; k++) reg_write(3'(k), cfg_vals[k]);
            reg_write(3'd7, $urandom);
            for (int n = 0; n < 150; n++) begin
                logic [127:0] d;
                if ($urandom_range(0, 3) == 0)
                    d = {rnd_word(), rnd_word(), rnd_word(), rnd_word()};
                else
                    d = {32'($signed(32'($urandom_range(0, 131072))) - 65536),
                         32'($urandom_range(0, 200000)) - 32'd100000,
                         32'($signed(32'($urandom_range(0, 131072))) - 65536),
                         32'($urandom_range(0, 200000)) - 32'd100000};
                send_tick(d);
            end
            drain_wait();
        end

        $display("Ran %0d ticks, %0d force transfers checked, across 8 register settings",
                 sent, got);
        if (errors == 0 && force_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
